@@ rtl/core/ofla_pkg.sv @@
// shared types, constants and codes of the ordered free-list record allocator
`default_nettype none
package ofla_pkg;

  // pool geometry
  localparam int MAX_RECORDS = 1024;
  localparam int CNT_W       = 11;
  localparam int WORD_W      = 32;
  localparam int WORDS       = MAX_RECORDS / WORD_W;
  localparam int IDX_W       = $clog2(WORDS);
  localparam int POS_W       = $clog2(WORD_W);

  // request types on the input channel
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_NEXT  = 2'd2;

  // command kinds between front and back
  localparam logic [2:0] K_NOP   = 3'd0;
  localparam logic [2:0] K_BAD   = 3'd1;
  localparam logic [2:0] K_ALLOC = 3'd2;
  localparam logic [2:0] K_FREE  = 3'd3;
  localparam logic [2:0] K_NEXT  = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BADSIZE = 3'd1;
  localparam logic [2:0] ST_NOSPACE = 3'd2;
  localparam logic [2:0] ST_END     = 3'd3;
  localparam logic [2:0] ST_NOTALLC = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_RECORD_SIZE = 2'd0;
  localparam logic [1:0] REG_CHUNK_SIZE  = 2'd1;
  localparam logic [1:0] REG_INIT_RECS   = 2'd2;

  // reset values
  localparam logic [12:0]      RST_RECORD_SIZE = 13'd8;
  localparam logic [CNT_W-1:0] RST_CHUNK_SIZE  = 11'd64;
  localparam logic [CNT_W-1:0] RST_INIT_RECS   = 11'd64;

  localparam int FIFO_DEPTH = 2;

  typedef struct packed {
    logic [2:0]       kind;
    logic [CNT_W-1:0] rec;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/ofla_front.sv @@
// front end: accepts requests and classifies them into commands
`default_nettype none
module ofla_front (
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [31:0]        in_tdata,
  input  wire logic [1:0]         in_tuser,
  input  wire logic [12:0]        record_size,
  input  wire logic               fifo_full,
  output logic                    push,
  output ofla_pkg::cmd_t          cmd
);

  logic [15:0]                 req_size;
  logic [ofla_pkg::CNT_W-1:0]  rec_number;
  logic                        too_big;

  assign req_size   = in_tdata[15:0];
  assign rec_number = in_tdata[26:16];
  assign in_tready  = !fifo_full;
  assign push       = in_tvalid && !fifo_full;

  // size check against the record size
  assign too_big = (req_size != 16'd0) && (req_size > {3'b000, record_size});

  // classify the request
  always_comb begin
    cmd.rec = rec_number;
    case (in_tuser)
      ofla_pkg::REQ_ALLOC: cmd.kind = too_big ? ofla_pkg::K_BAD : ofla_pkg::K_ALLOC;
      ofla_pkg::REQ_FREE:  cmd.kind = ofla_pkg::K_FREE;
      ofla_pkg::REQ_NEXT:  cmd.kind = ofla_pkg::K_NEXT;
      default:             cmd.kind = ofla_pkg::K_NOP;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/ofla_cmd_fifo.sv @@
// two-entry command queue between front and back
`default_nettype none
module ofla_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ofla_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output ofla_pkg::cmd_t      head
);

  localparam int PTR_W = $clog2(ofla_pkg::FIFO_DEPTH);

  ofla_pkg::cmd_t   mem_r [ofla_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign full  = (count_r == (PTR_W+1)'(ofla_pkg::FIFO_DEPTH));
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  // pointer and occupancy update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (push && !pop)      count_r <= count_r + (PTR_W+1)'(1);
      else if (pop && !push) count_r <= count_r - (PTR_W+1)'(1);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule
`default_nettype wire

@@ rtl/core/ofla_back.sv @@
// back end: free map, pool counters and word-serial command execution
`default_nettype none
module ofla_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [ofla_pkg::CNT_W-1:0]   chunk_size,
  input  wire logic                         restart,
  input  wire logic [ofla_pkg::CNT_W-1:0]   restart_n,
  input  wire logic                         cmd_valid,
  input  wire ofla_pkg::cmd_t               cmd,
  output logic                              cmd_pop,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [47:0]                       out_tdata
);

  localparam int CW = ofla_pkg::CNT_W;
  localparam int IW = ofla_pkg::IDX_W;
  localparam int PW = ofla_pkg::POS_W;
  localparam int WW = ofla_pkg::WORD_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ALLOC = 4'd1;
  localparam logic [3:0] S_FREE  = 4'd2;
  localparam logic [3:0] S_RUN   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_REL   = 4'd5;
  localparam logic [3:0] S_CLR   = 4'd6;
  localparam logic [3:0] S_SET   = 4'd7;
  localparam logic [3:0] S_NEXT  = 4'd8;

  logic [WW-1:0] map_r [ofla_pkg::WORDS];

  logic [3:0]    state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [PW-1:0] top_r, top_nxt;
  logic [CW-1:0] rec_r, rec_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] run_r, run_nxt;
  logic [CW-1:0] div_r, div_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic [CW-1:0] rel_r, rel_nxt;
  logic [CW-1:0] pool_r, pool_nxt;
  logic [CW-1:0] free_r, free_nxt;

  logic          out_valid_r;
  logic [47:0]   out_data_r;

  logic          emit;
  logic [CW-1:0] e_rec;
  logic [2:0]    e_stat;
  logic [CW-1:0] e_rel;
  logic          wr_en;
  logic [WW-1:0] wr_data;

  logic [WW-1:0] word;
  logic [WW-1:0] range_mask;
  logic [WW-1:0] next_mask;
  logic [CW:0]   two_chunk;
  logic [CW-1:0] room;
  logic [CW-1:0] grow;
  logic [CW-1:0] rec_m1;
  logic [CW-1:0] pool_m1;
  logic [CW-1:0] hi_m1;
  logic [5:0]    lead;
  logic [CW:0]   rem_sh;
  logic [CW-1:0] rel_calc;

  // lowest set bit of a word
  function automatic logic [PW-1:0] lowest_one(input logic [WW-1:0] x);
    logic [PW-1:0] p;
    p = '0;
    for (int i = WW-1; i >= 0; i--) begin
      if (x[i]) p = PW'(i);
    end
    return p;
  endfunction

  // run of ones from the top bit down
  function automatic logic [5:0] lead_ones(input logic [WW-1:0] x);
    logic [5:0] c;
    logic       found;
    c     = 6'(WW);
    found = 1'b0;
    for (int i = WW-1; i >= 0; i--) begin
      if (!found && !x[i]) begin
        c     = 6'(WW-1-i);
        found = 1'b1;
      end
    end
    return c;
  endfunction

  // map word for a pool of n records all free
  function automatic logic [WW-1:0] fill_word(input logic [IW-1:0] w,
                                              input logic [CW-1:0] n);
    logic [WW-1:0] m;
    for (int i = 0; i < WW; i++) begin
      m[i] = ({1'b0, w, PW'(i)} < n);
    end
    return m;
  endfunction

  assign word      = map_r[idx_r];
  assign two_chunk = {chunk_size, 1'b0};
  assign room      = CW'(ofla_pkg::MAX_RECORDS) - pool_r;
  assign grow      = (chunk_size < room) ? chunk_size : room;
  assign rec_m1    = cmd.rec - CW'(1);
  assign pool_m1   = pool_r - CW'(1);
  assign hi_m1     = hi_r - CW'(1);
  assign lead      = lead_ones(word << (PW'(WW-1) - top_r));
  assign rem_sh    = {rem_r, div_r[CW-1]};
  assign rel_calc  = run_r - rem_r - chunk_size;

  // bit masks over the current word
  always_comb begin
    for (int i = 0; i < WW; i++) begin
      range_mask[i] = ({1'b0, idx_r, PW'(i)} >= lo_r) && ({1'b0, idx_r, PW'(i)} < hi_r);
      next_mask[i]  = !word[i] && ({1'b0, idx_r, PW'(i)} >= rec_r)
                      && ({1'b0, idx_r, PW'(i)} < pool_r);
    end
  end

  // command sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    top_nxt   = top_r;
    rec_nxt   = rec_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    run_nxt   = run_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    rel_nxt   = rel_r;
    pool_nxt  = pool_r;
    free_nxt  = free_r;
    emit      = 1'b0;
    e_rec     = '0;
    e_stat    = ofla_pkg::ST_OK;
    e_rel     = '0;
    wr_en     = 1'b0;
    wr_data   = word;
    cmd_pop   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid && !out_valid_r) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            ofla_pkg::K_BAD: begin
              emit   = 1'b1;
              e_stat = ofla_pkg::ST_BADSIZE;
            end
            ofla_pkg::K_ALLOC: begin
              if (free_r == '0) begin
                if (grow == '0) begin
                  emit   = 1'b1;
                  e_stat = ofla_pkg::ST_NOSPACE;
                end else begin
                  // first new record is taken, the rest join the free set
                  rec_nxt  = pool_r + CW'(1);
                  lo_nxt   = pool_r + CW'(1);
                  hi_nxt   = pool_r + grow;
                  pool_nxt = pool_r + grow;
                  free_nxt = grow - CW'(1);
                  if (grow == CW'(1)) begin
                    emit  = 1'b1;
                    e_rec = pool_r + CW'(1);
                  end else begin
                    idx_nxt   = lo_nxt[PW+IW-1:PW];
                    state_nxt = S_SET;
                  end
                end
              end else begin
                idx_nxt   = '0;
                state_nxt = S_ALLOC;
              end
            end
            ofla_pkg::K_FREE: begin
              if (cmd.rec == '0 || cmd.rec > pool_r) begin
                emit   = 1'b1;
                e_stat = ofla_pkg::ST_NOTALLC;
              end else begin
                rec_nxt   = rec_m1;
                idx_nxt   = rec_m1[PW+IW-1:PW];
                state_nxt = S_FREE;
              end
            end
            ofla_pkg::K_NEXT: begin
              if (cmd.rec >= pool_r) begin
                emit   = 1'b1;
                e_stat = ofla_pkg::ST_END;
              end else begin
                rec_nxt   = cmd.rec;
                idx_nxt   = cmd.rec[PW+IW-1:PW];
                state_nxt = S_NEXT;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC: begin
        if (word != '0) begin
          wr_en              = 1'b1;
          wr_data            = word;
          wr_data[lowest_one(word)] = 1'b0;
          free_nxt           = free_r - CW'(1);
          emit               = 1'b1;
          e_rec              = {1'b0, idx_r, lowest_one(word)} + CW'(1);
          state_nxt          = S_IDLE;
        end else if (idx_r == IW'(ofla_pkg::WORDS-1)) begin
          emit      = 1'b1;
          e_stat    = ofla_pkg::ST_NOSPACE;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_FREE: begin
        if (word[rec_r[PW-1:0]]) begin
          emit      = 1'b1;
          e_stat    = ofla_pkg::ST_NOTALLC;
          state_nxt = S_IDLE;
        end else begin
          wr_en                = 1'b1;
          wr_data[rec_r[PW-1:0]] = 1'b1;
          free_nxt             = free_r + CW'(1);
          if (chunk_size == '0 || {1'b0, free_nxt} <= two_chunk) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = pool_m1[PW+IW-1:PW];
            top_nxt   = pool_m1[PW-1:0];
            run_nxt   = '0;
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        // trailing free run, one word a cycle from the pool end down
        run_nxt = run_r + CW'(lead);
        if (lead == {1'b0, top_r} + 6'd1 && idx_r != '0) begin
          idx_nxt = idx_r - IW'(1);
          top_nxt = PW'(WW-1);
        end else if ({1'b0, run_nxt} < two_chunk) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          div_nxt   = run_nxt;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // restoring division, one quotient bit a cycle
        rem_nxt = (rem_sh >= {1'b0, chunk_size}) ? CW'(rem_sh - {1'b0, chunk_size})
                                                 : CW'(rem_sh);
        div_nxt = div_r << 1;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(CW-1)) state_nxt = S_REL;
      end
      S_REL: begin
        rel_nxt   = rel_calc;
        lo_nxt    = pool_r - rel_calc;
        hi_nxt    = pool_r;
        pool_nxt  = pool_r - rel_calc;
        free_nxt  = free_r - rel_calc;
        idx_nxt   = lo_nxt[PW+IW-1:PW];
        state_nxt = S_CLR;
      end
      S_CLR: begin
        wr_en   = 1'b1;
        wr_data = word & ~range_mask;
        if (idx_r == hi_m1[PW+IW-1:PW]) begin
          emit      = 1'b1;
          e_rel     = rel_r;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_SET: begin
        wr_en   = 1'b1;
        wr_data = word | range_mask;
        if (idx_r == hi_m1[PW+IW-1:PW]) begin
          emit      = 1'b1;
          e_rec     = rec_r;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_NEXT: begin
        if (next_mask != '0) begin
          emit      = 1'b1;
          e_rec     = {1'b0, idx_r, lowest_one(next_mask)} + CW'(1);
          state_nxt = S_IDLE;
        end else if (idx_r == IW'(ofla_pkg::WORDS-1)) begin
          emit      = 1'b1;
          e_stat    = ofla_pkg::ST_END;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pool_r      <= ofla_pkg::RST_INIT_RECS;
      free_r      <= ofla_pkg::RST_INIT_RECS;
      out_valid_r <= 1'b0;
    end else if (restart) begin
      state_r <= S_IDLE;
      pool_r  <= restart_n;
      free_r  <= restart_n;
    end else begin
      state_r <= state_nxt;
      pool_r  <= pool_nxt;
      free_r  <= free_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // working registers and result word
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    top_r <= top_nxt;
    rec_r <= rec_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    run_r <= run_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    rel_r <= rel_nxt;
    if (emit) begin
      out_data_r <= {1'b0, e_rel, free_nxt, pool_nxt, e_stat, e_rec};
    end
  end

  // free map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < ofla_pkg::WORDS; w++) begin
        map_r[w] <= fill_word(IW'(w), ofla_pkg::RST_INIT_RECS);
      end
    end else if (restart) begin
      for (int w = 0; w < ofla_pkg::WORDS; w++) begin
        map_r[w] <= fill_word(IW'(w), restart_n);
      end
    end else if (wr_en) begin
      map_r[idx_r] <= wr_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

@@ rtl/core/ordered_free_list_record_allocator_top.sv @@
// top level of the ordered free-list record allocator
//
// Requests come in on the in_ stream: tuser carries the request type
// (allocate, free, next), tdata the byte size and the record number.
// Every request gives exactly one result on the out_ stream with the
// record number, a status code and the pool and free counts after it.
// The front end classifies each request into a two-entry command queue;
// the back end works through a 32 x 32 free map one word a cycle.
// Bad-size, no-op and range-failed requests are answered straight from
// idle; a free that releases chunks scans the trailing free run word by
// word from the pool end down, divides it by the chunk size, computes the
// release and clears the released words.
// One request is worked at a time; the back end takes the next command the
// cycle after the result is taken, so a stalled receiver holds the queue,
// and in_tready falls once the queue is full.
// Reset restores record size 8, chunk size 64 and a pool of 64 free records;
// writing initial_records restarts the pool the same way. The user must
// write configuration only while the block is idle; nothing enforces it.
`default_nettype none
module ordered_free_list_record_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // req_size[15:0], rec_number[26:16]
  input  wire logic [1:0]  in_tuser,   // req_type[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // result_record[10:0], status[13:11],
                                       // pool_records[24:14], free_records[35:25],
                                       // released_records[46:36]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int CW = ofla_pkg::CNT_W;

  logic [12:0]    record_size_r;
  logic [CW-1:0]  chunk_size_r;
  logic [CW-1:0]  init_recs_r;
  logic           cfg_wr;
  logic           restart;
  logic [CW-1:0]  restart_n;

  logic           push;
  logic           fifo_full;
  logic           fifo_valid;
  logic           pop;
  ofla_pkg::cmd_t front_cmd;
  ofla_pkg::cmd_t head_cmd;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign restart    = cfg_wr && (cfg_paddr[3:2] == ofla_pkg::REG_INIT_RECS);
  assign restart_n  = (cfg_pwdata[10:0] > CW'(ofla_pkg::MAX_RECORDS))
                      ? CW'(ofla_pkg::MAX_RECORDS) : cfg_pwdata[10:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_size_r <= ofla_pkg::RST_RECORD_SIZE;
      chunk_size_r  <= ofla_pkg::RST_CHUNK_SIZE;
      init_recs_r   <= ofla_pkg::RST_INIT_RECS;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        ofla_pkg::REG_RECORD_SIZE: record_size_r <= cfg_pwdata[12:0];
        ofla_pkg::REG_CHUNK_SIZE:  chunk_size_r  <= cfg_pwdata[10:0];
        ofla_pkg::REG_INIT_RECS:   init_recs_r   <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (cfg_paddr[3:2])
      ofla_pkg::REG_RECORD_SIZE: cfg_prdata = {19'd0, record_size_r};
      ofla_pkg::REG_CHUNK_SIZE:  cfg_prdata = {21'd0, chunk_size_r};
      ofla_pkg::REG_INIT_RECS:   cfg_prdata = {21'd0, init_recs_r};
      default:                   cfg_prdata = '0;
    endcase
  end

  ofla_front u_front (
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .record_size (record_size_r),
    .fifo_full   (fifo_full),
    .push        (push),
    .cmd         (front_cmd)
  );

  ofla_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (front_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .valid    (fifo_valid),
    .head     (head_cmd)
  );

  ofla_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .chunk_size (chunk_size_r),
    .restart    (restart),
    .restart_n  (restart_n),
    .cmd_valid  (fifo_valid),
    .cmd        (head_cmd),
    .cmd_pop    (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

@@ tb/sv/pool_result_checker.sv @@
// request/result checker: predicts each allocator result and compares it on the out stream
module pool_result_checker
  import ofla_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // req_size[15:0], rec_number[26:16]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // result_record, status, pool, free, released
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic [10:0] rec;
    logic [2:0]  status;
    logic [10:0] pool;
    logic [10:0] free_n;
    logic [10:0] released;
  } pool_result_t;

  // shadow copy of the pool and its registers
  bit          slot_free [MAX_RECORDS];
  int unsigned pool_cnt;
  int unsigned free_cnt;
  int unsigned rec_size;
  int unsigned chunk;

  pool_result_t expected_results [$];

  function automatic void restart_pool(int unsigned n);
    if (n > MAX_RECORDS) n = MAX_RECORDS;
    for (int i = 0; i < MAX_RECORDS; i++) slot_free[i] = (i < n);
    pool_cnt = n;
    free_cnt = n;
  endfunction

  function automatic pool_result_t predict_request(logic [1:0] kind, logic [15:0] size,
                                                   logic [10:0] rec);
    pool_result_t r;
    int unsigned  grow;
    int unsigned  run;
    int unsigned  blocks;
    int unsigned  rel;
    bit           found;
    r = '0;
    case (kind)
      REQ_ALLOC: begin
        if (size != 0 && size > rec_size) begin
          r.status = ST_BADSIZE;
        end else begin
          // grow by one chunk when nothing is free
          if (free_cnt == 0) begin
            grow = chunk;
            if (grow > MAX_RECORDS - pool_cnt) grow = MAX_RECORDS - pool_cnt;
            if (grow == 0) begin
              r.status = ST_NOSPACE;
            end else begin
              for (int i = pool_cnt; i < pool_cnt + grow; i++) slot_free[i] = 1;
              pool_cnt += grow;
              free_cnt += grow;
            end
          end
          if (r.status != ST_NOSPACE) begin
            found = 0;
            for (int i = 0; i < pool_cnt && !found; i++) begin
              if (slot_free[i]) begin
                slot_free[i] = 0;
                free_cnt--;
                r.rec = 11'(i + 1);
                found = 1;
              end
            end
            if (!found) r.status = ST_NOSPACE;
          end
        end
      end
      REQ_FREE: begin
        if (rec == 0 || rec > pool_cnt || slot_free[rec-1]) begin
          r.status = ST_NOTALLC;
        end else begin
          slot_free[rec-1] = 1;
          free_cnt++;
          // give back whole chunks of a long free run at the pool end
          if (chunk != 0 && free_cnt > 2 * chunk && slot_free[pool_cnt-1]) begin
            run = 0;
            while (run < pool_cnt && slot_free[pool_cnt-1-run]) run++;
            blocks = run / chunk;
            if (blocks > 1) begin
              rel = (blocks - 1) * chunk;
              for (int i = pool_cnt - rel; i < pool_cnt; i++) slot_free[i] = 0;
              pool_cnt -= rel;
              free_cnt -= rel;
              r.released = 11'(rel);
            end
          end
        end
      end
      REQ_NEXT: begin
        r.status = ST_END;
        if (rec <= pool_cnt) begin
          for (int i = rec; i < pool_cnt; i++) begin
            if (!slot_free[i]) begin
              r.rec    = 11'(i + 1);
              r.status = ST_OK;
              break;
            end
          end
        end
      end
      default: ;
    endcase
    r.pool   = 11'(pool_cnt);
    r.free_n = 11'(free_cnt);
    return r;
  endfunction

  // watch register writes, results and requests
  always @(posedge clk) begin
    pool_result_t got;
    pool_result_t want;
    if (!rst_n) begin
      rec_size = RST_RECORD_SIZE;
      chunk    = RST_CHUNK_SIZE;
      restart_pool(RST_INIT_RECS);
      expected_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_RECORD_SIZE: rec_size = cfg_pwdata[12:0];
          REG_CHUNK_SIZE:  chunk    = cfg_pwdata[10:0];
          REG_INIT_RECS:   restart_pool(cfg_pwdata[10:0]);
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.rec      = out_tdata[10:0];
        got.status   = out_tdata[13:11];
        got.pool     = out_tdata[24:14];
        got.free_n   = out_tdata[35:25];
        got.released = out_tdata[46:36];
        if (expected_results.size() == 0) begin
          $error("result with no request waiting: %h", out_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got.rec != want.rec) begin
            $error("result_record: expected %0d, got %0d", want.rec, got.rec);
            mismatches++;
          end
          if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.pool != want.pool) begin
            $error("pool_records: expected %0d, got %0d", want.pool, got.pool);
            mismatches++;
          end
          if (got.free_n != want.free_n) begin
            $error("free_records: expected %0d, got %0d", want.free_n, got.free_n);
            mismatches++;
          end
          if (got.released != want.released) begin
            $error("released_records: expected %0d, got %0d", want.released, got.released);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_request(in_tuser, in_tdata[15:0], in_tdata[26:16]));
    end
    pending = expected_results.size();
  end

endmodule

@@ tb/sv/tb.sv @@
// testbench top: clock, reset, request and register stimulus, verdict
module tb;
  import ofla_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 120;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // req_size[15:0], rec_number[26:16]
  logic [1:0]  in_tuser;   // req_type[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // result_record[10:0], status[13:11], pool[24:14],
                           // free[35:25], released[46:36]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int          mismatches;
  int          pending;
  int          cycles;
  int          held [$];      // records the block has handed out
  logic [1:0]  sent_kinds [$];
  int          cur_rec_size;

  ordered_free_list_record_allocator_top DUT (.*);

  pool_result_checker checker_i (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr, .cfg_pwdata,
    .mismatches, .pending
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL ordered_free_list_record_allocator_top");
      $finish;
    end
  end

  // track handed-out records so frees mostly hit allocated ones
  always @(posedge clk) begin
    logic [1:0] k;
    if (rst_n) begin
      if (in_tvalid && in_tready) sent_kinds.push_back(in_tuser);
      if (out_tvalid && out_tready && sent_kinds.size() > 0) begin
        k = sent_kinds.pop_front();
        if (k == REQ_ALLOC && out_tdata[13:11] == ST_OK) held.push_back(out_tdata[10:0]);
      end
    end
  end

  // receiver stalls: mostly short, a few long, with stall-free stretches
  initial begin
    int n;
    out_tready = 0;
    forever begin
      @(negedge clk);
      out_tready <= 1;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8))
        @(negedge clk);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      out_tready <= 0;
      repeat (n - 1) @(negedge clk);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one request: optional gap, then hold until accepted
  task automatic send_request(logic [1:0] kind, logic [15:0] size, logic [10:0] rec);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= kind;
    in_tdata  <= {5'b0, rec, size};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic release_bus();
    @(negedge clk);
    in_tvalid <= 0;
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1;
    cfg_pwrite  <= 1;
    cfg_penable <= 0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel    <= 0;
    cfg_penable <= 0;
    cfg_pwrite  <= 0;
  endtask

  // wait out every result, then let the back end settle
  task automatic drain();
    release_bus();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_pool(int rsize, int chk, int init_recs);
    drain();
    write_register(REG_RECORD_SIZE, rsize);
    write_register(REG_CHUNK_SIZE, chk);
    write_register(REG_INIT_RECS, init_recs);
    cur_rec_size = rsize;
    held.delete();
  endtask

  // mostly well-formed allocate/free/next traffic with some noise
  task automatic random_requests(int count);
    int          r;
    int          idx;
    logic [15:0] size;
    logic [10:0] rec;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 42) begin
        size = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, cur_rec_size));
        send_request(REQ_ALLOC, size, 11'($urandom));
      end else if (r < 80) begin
        if (held.size() > 0 && $urandom_range(0, 9) != 0) begin
          idx = $urandom_range(0, held.size() - 1);
          rec = held[idx];
          held.delete(idx);
        end else begin
          rec = 11'($urandom);
        end
        send_request(REQ_FREE, 16'($urandom), rec);
      end else if (r < 95) begin
        if (held.size() > 0 && $urandom_range(0, 2) != 0)
          rec = held[$urandom_range(0, held.size() - 1)];
        else if ($urandom_range(0, 1) == 0)
          rec = 0;
        else
          rec = 11'($urandom);
        send_request(REQ_NEXT, 16'($urandom), rec);
      end else begin
        send_request(2'd3, 16'($urandom), 11'($urandom));
      end
    end
  endtask

  initial begin
    in_tvalid   = 0;
    in_tdata    = 0;
    in_tuser    = 0;
    cfg_psel    = 0;
    cfg_penable = 0;
    cfg_pwrite  = 0;
    cfg_paddr   = 0;
    cfg_pwdata  = 0;
    cur_rec_size = 8;
    rst_n       = 0;
    repeat (12) @(negedge clk);
    rst_n = 1;

    // directed: field extremes and special cases on the reset pool
    send_request(REQ_NEXT, 16'd0, 11'd0);          // nothing allocated yet
    send_request(REQ_ALLOC, 16'd0, 11'd0);         // zero size means one record
    send_request(REQ_ALLOC, 16'd8, 11'h7ff);
    send_request(REQ_ALLOC, 16'd9, 11'd0);         // just over record size
    send_request(REQ_ALLOC, 16'hffff, 11'd0);
    send_request(REQ_ALLOC, 16'd1, 11'd0);
    send_request(REQ_NEXT, 16'hffff, 11'd0);
    send_request(REQ_NEXT, 16'd0, 11'd1);
    send_request(REQ_NEXT, 16'd0, 11'd3);          // end reached
    send_request(REQ_NEXT, 16'd0, 11'h7ff);        // beyond the pool
    send_request(REQ_FREE, 16'd0, 11'd0);          // record zero
    send_request(REQ_FREE, 16'd0, 11'h7ff);        // beyond the pool
    send_request(REQ_FREE, 16'd0, 11'd60);         // already free
    send_request(REQ_FREE, 16'd0, 11'd2);
    send_request(REQ_FREE, 16'd0, 11'd2);          // double free
    send_request(2'd3, 16'hffff, 11'h7ff);         // unknown type
    send_request(REQ_ALLOC, 16'd0, 11'd0);
    random_requests(120);

    // tiny pool, no growth: out of space
    set_pool(8, 0, 1);
    send_request(REQ_ALLOC, 16'd0, 11'd0);
    send_request(REQ_ALLOC, 16'd0, 11'd0);
    send_request(REQ_FREE, 16'd0, 11'd1);
    random_requests(100);

    // chunk of one: frequent growth and release
    set_pool(1, 1, 1);
    random_requests(200);

    // small chunks, deep grow/release churn
    set_pool(16, 4, 8);
    random_requests(250);

    // growth saturating at the pool limit
    set_pool(4096, 1024, 1);
    random_requests(150);

    // initial size above the limit, odd chunk
    set_pool(100, 3, 2047);
    random_requests(150);

    // empty pool at start, widest register values
    set_pool(13'h1fff, 11'h7ff, 0);
    random_requests(100);

    set_pool(2, 2, 5);
    random_requests(150);

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("PASS ordered_free_list_record_allocator_top");
    end else begin
      $display("FAIL ordered_free_list_record_allocator_top");
    end
    $finish;
  end

endmodule
